@@ design/sonar_avoid_wander_heading_macros.svh @@
// Assertion macros for the sonar avoid/wander heading block.
`ifndef SONAR_AVOID_WANDER_HEADING_MACROS_SVH
`define SONAR_AVOID_WANDER_HEADING_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SAWH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define SAWH_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/sawh_pkg.sv @@
// Package: types, codes and constants of the sonar avoid/wander heading block.
package sawh_pkg;

  localparam int SENSOR_COUNT = 4;
  localparam int SIDX_W       = $clog2(SENSOR_COUNT);
  localparam int CFG_IDX_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WANDER_PERIOD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_FORCE     = 8'd1;

  localparam logic [31:0] WANDER_PERIOD_RST = 32'd6000;
  localparam logic [31:0] SIG_FORCE_RST     = 32'd0;

  // Sensor slots
  localparam logic [SIDX_W-1:0] SENS_FRONT = 2'd0;
  localparam logic [SIDX_W-1:0] SENS_RIGHT = 2'd1;
  localparam logic [SIDX_W-1:0] SENS_BACK  = 2'd2;
  localparam logic [SIDX_W-1:0] SENS_LEFT  = 2'd3;

  typedef struct packed {
    logic        [15:0] dist_front;
    logic        [15:0] dist_right;
    logic        [15:0] dist_back;
    logic        [15:0] dist_left;
    logic        [31:0] time_now;
    logic signed [15:0] rand_x;
    logic signed [15:0] rand_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               wandered;
    logic               saturated;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_XSEL, OP_MAC, OP_MNEXT, OP_DINIT, OP_DSTEP, OP_DDONE,
    OP_HSQ0, OP_HSQ1, OP_SINIT, OP_SSTEP, OP_QINIT, OP_QSTEP, OP_WDONE,
    OP_SUM, OP_NX, OP_NY, OP_NT, OP_FIN
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_XSEL, S_MAC, S_MNEXT, S_DINIT, S_DSTEP, S_DDONE,
    S_HSQ0, S_HSQ1, S_SINIT, S_SSTEP, S_QINIT, S_QSTEP, S_WDONE,
    S_SUM, S_NX, S_NY, S_NT, S_FIN
  } state_t;

  typedef struct packed {
    dp_op_t            op;
    logic [SIDX_W-1:0] sidx;
    logic [1:0]        limb;
  } cmd_t;

  typedef struct packed {
    logic wander;
  } stat_t;

endpackage

@@ design/sonar_avoid_wander_heading.sv @@
// Top level of the sonar avoid/wander heading block: controller plus datapath.
//
// Takes four sonar ranges, a millisecond time stamp and a random pair per request
// and returns one velocity request (Q16.16, saturated) with wandered/saturated
// flags. Each range d gives a repulsive magnitude floor(2^136 / X^5) with
// X = 40960*D + 16777, clipped to 2^31. X^5 is built with one shared 32x32
// multiplier, one partial product per cycle, and the quotient comes from a
// restoring divider producing one bit per cycle (32 steps). When the wander
// period has elapsed, or on the first request after reset, the previous heading
// plus the random pair is normalized with a bit-serial square root (32 steps)
// and a pair of bit-serial dividers (16 steps). The output is zeroed unless
// vx^2 + vy^2 > significant_force^2.
// Rate: one request at a time; the four 32-step reciprocal divisions dominate
// the time from acceptance to result, which is longer when a new wander heading
// is built. A finished result waits in an output register, so the next request
// is accepted while it is still waiting to be taken. Configuration writes
// (cfg_index 0: wander_period_ms, 1: significant_force, others ignored) are
// always accepted and must be issued only while the block is idle.
module sonar_avoid_wander_heading (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sawh_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sawh_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sawh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import sawh_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  sawh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sawh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

@@ design/sawh_dp.sv @@
// Datapath: sensor force magnitudes, wander heading and velocity threshold.
module sawh_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  sawh_pkg::cmd_t                 cmd,
  output sawh_pkg::stat_t                stat,
  input  sawh_pkg::in_t                  in_data,
  output sawh_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  input  logic [sawh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import sawh_pkg::*;

  localparam logic signed [34:0] SUM_MAX = 35'sd2147483647;
  localparam logic signed [34:0] SUM_MIN = -35'sd2147483648;

  logic [31:0] period, sfrc;
  logic [31:0] last_time;
  logic        started;
  logic signed [15:0] prev_x, prev_y;

  logic [15:0] sonar [SENSOR_COUNT];
  logic [31:0] now;
  logic signed [16:0] hx, hy;
  logic        wander, clip;

  logic [31:0]  xv;
  logic [159:0] pw, acc;
  logic [136:0] rem;
  logic [190:0] dsh;
  logic [31:0]  q;
  logic         preclip;
  logic [31:0]  mag [SENSOR_COUNT];

  logic [33:0] sacc;
  logic [63:0] sv, sres, sone;
  logic [47:0] dv, remx, remy;
  logic [15:0] qx, qy;

  logic signed [31:0] vx, vy;
  logic [63:0] nacc, tsq;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [16:0] habs_x, habs_y;
  logic [31:0] ax, ay, xval;
  logic [63:0] st;
  logic signed [34:0] fx, fy, wtx, wty;
  logic signed [15:0] wx, wy;
  logic pass;

  assign habs_x = hx[16] ? 17'(-hx) : 17'(hx);
  assign habs_y = hy[16] ? 17'(-hy) : 17'(hy);
  assign ax = vx[31] ? (~vx + 32'd1) : vx;
  assign ay = vy[31] ? (~vy + 32'd1) : vy;
  // 10d + 0.001 in 2^-24 units: 40960*D + 16777
  assign xval = ({16'b0, sonar[cmd.sidx]} << 15) + ({16'b0, sonar[cmd.sidx]} << 13) + 32'd16777;
  assign st = sres + sone;
  assign stat.wander = wander;

  // Shared 32x32 multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MAC:  begin mul_a = pw[32*cmd.limb +: 32]; mul_b = xv; end
      OP_HSQ0: begin mul_a = {15'b0, habs_x}; mul_b = {15'b0, habs_x}; end
      OP_HSQ1: begin mul_a = {15'b0, habs_y}; mul_b = {15'b0, habs_y}; end
      OP_NX:   begin mul_a = ax; mul_b = ax; end
      OP_NY:   begin mul_a = ay; mul_b = ay; end
      OP_NT:   begin mul_a = sfrc; mul_b = sfrc; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    wx = (sacc == '0) ? 16'sd0 : (hx[16] ? -$signed(qx) : $signed(qx));
    wy = (sacc == '0) ? 16'sd0 : (hy[16] ? -$signed(qy) : $signed(qy));
    wtx = wander ? {{17{prev_x[15]}}, prev_x, 2'b0} : '0;
    wty = wander ? {{17{prev_y[15]}}, prev_y, 2'b0} : '0;
    fx = $signed({3'b0, mag[SENS_LEFT]}) - $signed({3'b0, mag[SENS_RIGHT]}) + wtx;
    fy = $signed({3'b0, mag[SENS_BACK]}) - $signed({3'b0, mag[SENS_FRONT]}) + wty;
    pass = nacc > tsq;
  end

  // Configuration and persistent wander state
  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= WANDER_PERIOD_RST;
      sfrc      <= SIG_FORCE_RST;
      last_time <= '0;
      started   <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_WANDER_PERIOD: period <= cfg_data;
          REG_SIG_FORCE:     sfrc   <= cfg_data;
          default:           ;
        endcase
      end
      if (cmd.op == OP_WDONE) begin
        prev_x    <= wx;
        prev_y    <= wy;
        last_time <= now;
        started   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        sonar[SENS_FRONT] <= in_data.dist_front;
        sonar[SENS_RIGHT] <= in_data.dist_right;
        sonar[SENS_BACK]  <= in_data.dist_back;
        sonar[SENS_LEFT]  <= in_data.dist_left;
        now    <= in_data.time_now;
        hx     <= 17'(prev_x) + 17'(in_data.rand_x);
        hy     <= 17'(prev_y) + 17'(in_data.rand_y);
        wander <= !started || ((in_data.time_now - last_time) >= period);
        clip   <= 1'b0;
      end
      OP_XSEL: begin
        xv  <= xval;
        pw  <= {128'b0, xval};
        acc <= '0;
      end
      OP_MAC:   acc <= acc + ({96'b0, mul_p} << {cmd.limb, 5'b0});
      OP_MNEXT: begin
        pw  <= acc;
        acc <= '0;
      end
      OP_DINIT: begin
        rem     <= 137'(1) << 136;
        dsh     <= {pw, 31'b0};
        q       <= '0;
        preclip <= pw <= (160'(1) << 104);
      end
      OP_DSTEP: begin
        if (dsh <= {54'b0, rem}) begin
          rem <= rem - dsh[136:0];
          q   <= {q[30:0], 1'b1};
        end else begin
          q   <= {q[30:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      OP_DDONE: begin
        if (preclip || q > 32'h8000_0000) begin
          mag[cmd.sidx] <= 32'h8000_0000;
          clip          <= 1'b1;
        end else begin
          mag[cmd.sidx] <= q;
        end
      end
      OP_HSQ0: sacc <= mul_p[33:0];
      OP_HSQ1: sacc <= sacc + mul_p[33:0];
      OP_SINIT: begin
        sv   <= {2'b0, sacc, 28'b0};
        sres <= '0;
        sone <= 64'(1) << 62;
      end
      OP_SSTEP: begin
        if (sv >= st) begin
          sv   <= sv - st;
          sres <= (sres >> 1) + sone;
        end else begin
          sres <= sres >> 1;
        end
        sone <= sone >> 2;
      end
      OP_QINIT: begin
        dv   <= {1'b0, sres[31:0], 15'b0};
        remx <= {3'b0, habs_x, 28'b0};
        remy <= {3'b0, habs_y, 28'b0};
        qx   <= '0;
        qy   <= '0;
      end
      OP_QSTEP: begin
        if (dv <= remx) begin
          remx <= remx - dv;
          qx   <= {qx[14:0], 1'b1};
        end else begin
          qx   <= {qx[14:0], 1'b0};
        end
        if (dv <= remy) begin
          remy <= remy - dv;
          qy   <= {qy[14:0], 1'b1};
        end else begin
          qy   <= {qy[14:0], 1'b0};
        end
        dv <= dv >> 1;
      end
      OP_SUM: begin
        if (fx > SUM_MAX) begin
          vx <= 32'sh7FFF_FFFF;
        end else if (fx < SUM_MIN) begin
          vx <= 32'sh8000_0000;
        end else begin
          vx <= fx[31:0];
        end
        if (fy > SUM_MAX) begin
          vy <= 32'sh7FFF_FFFF;
        end else if (fy < SUM_MIN) begin
          vy <= 32'sh8000_0000;
        end else begin
          vy <= fy[31:0];
        end
        clip <= clip || (fx > SUM_MAX) || (fx < SUM_MIN) ||
                (fy > SUM_MAX) || (fy < SUM_MIN);
      end
      OP_NX: nacc <= mul_p;
      OP_NY: nacc <= nacc + mul_p;
      OP_NT: tsq  <= mul_p;
      OP_FIN: begin
        out_data.vel_x     <= pass ? vx : 32'sd0;
        out_data.vel_y     <= pass ? vy : 32'sd0;
        out_data.wandered  <= wander;
        out_data.saturated <= clip;
      end
      default: ;
    endcase
  end

endmodule

@@ design/sawh_ctrl.sv @@
// Controller: sequences the datapath through one request.
`include "sonar_avoid_wander_heading_macros.svh"
module sawh_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sawh_pkg::stat_t stat,
  output sawh_pkg::cmd_t  cmd
);
  import sawh_pkg::*;

  localparam logic [4:0] DIV_LAST  = 5'd31;
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] QUOT_LAST = 5'd15;
  localparam logic [1:0] RND_LAST  = 2'd3;
  localparam logic [SIDX_W-1:0] SIDX_LAST = SIDX_W'(SENSOR_COUNT - 1);

  state_t state, state_next;
  logic [SIDX_W-1:0] sidx, sidx_next;
  logic [1:0] rnd, rnd_next, limb, limb_next;
  logic [4:0] cnt, cnt_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sidx      <= '0;
      rnd       <= '0;
      limb      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sidx      <= sidx_next;
      rnd       <= rnd_next;
      limb      <= limb_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    sidx_next      = sidx;
    rnd_next       = rnd;
    limb_next      = limb;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd.op         = OP_NONE;
    cmd.sidx       = sidx;
    cmd.limb       = limb;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          sidx_next  = '0;
          state_next = S_XSEL;
        end
      end
      S_XSEL: begin
        cmd.op     = OP_XSEL;
        rnd_next   = '0;
        limb_next  = '0;
        state_next = S_MAC;
      end
      S_MAC: begin
        cmd.op = OP_MAC;
        if (limb == rnd) state_next = S_MNEXT;
        else limb_next = limb + 2'd1;
      end
      S_MNEXT: begin
        cmd.op = OP_MNEXT;
        if (rnd == RND_LAST) begin
          state_next = S_DINIT;
        end else begin
          rnd_next   = rnd + 2'd1;
          limb_next  = '0;
          state_next = S_MAC;
        end
      end
      S_DINIT: begin
        cmd.op     = OP_DINIT;
        cnt_next   = '0;
        state_next = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = OP_DSTEP;
        if (cnt == DIV_LAST) state_next = S_DDONE;
        else cnt_next = cnt + 5'd1;
      end
      S_DDONE: begin
        cmd.op = OP_DDONE;
        if (sidx == SIDX_LAST) begin
          state_next = stat.wander ? S_HSQ0 : S_SUM;
        end else begin
          sidx_next  = sidx + SIDX_W'(1);
          state_next = S_XSEL;
        end
      end
      S_HSQ0: begin cmd.op = OP_HSQ0; state_next = S_HSQ1; end
      S_HSQ1: begin cmd.op = OP_HSQ1; state_next = S_SINIT; end
      S_SINIT: begin
        cmd.op     = OP_SINIT;
        cnt_next   = '0;
        state_next = S_SSTEP;
      end
      S_SSTEP: begin
        cmd.op = OP_SSTEP;
        if (cnt == SQRT_LAST) state_next = S_QINIT;
        else cnt_next = cnt + 5'd1;
      end
      S_QINIT: begin
        cmd.op     = OP_QINIT;
        cnt_next   = '0;
        state_next = S_QSTEP;
      end
      S_QSTEP: begin
        cmd.op = OP_QSTEP;
        if (cnt == QUOT_LAST) state_next = S_WDONE;
        else cnt_next = cnt + 5'd1;
      end
      S_WDONE: begin cmd.op = OP_WDONE; state_next = S_SUM; end
      S_SUM:   begin cmd.op = OP_SUM;   state_next = S_NX; end
      S_NX:    begin cmd.op = OP_NX;    state_next = S_NY; end
      S_NY:    begin cmd.op = OP_NY;    state_next = S_NT; end
      S_NT:    begin cmd.op = OP_NT;    state_next = S_FIN; end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.op         = OP_FIN;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `SAWH_ASSERT_NXT(a_load_starts, clk, rst, in_valid && in_ready, state == S_XSEL, "request did not start sensor pass")
  `SAWH_ASSERT_NXT(a_fin_valid, clk, rst, cmd.op == OP_FIN, out_valid && state == S_IDLE, "finished result not presented")
  `SAWH_ASSERT_IMP(a_limb_range, clk, rst, cmd.op == OP_MAC, limb <= rnd, "limb beyond current power")
  `SAWH_ASSERT_NXT(a_div_len, clk, rst, state == S_DSTEP && cnt == DIV_LAST, state == S_DDONE, "divider ran long")

endmodule
